@@ design/lpht_pkg.sv @@
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Shared constants, status codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package lpht_pkg;

   localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
   localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;
   localparam logic [7:0]  LOAD_RESET = 8'hBF;
   localparam int          LOAD_SHIFT = 8;

   localparam logic [2:0] ST_ADDED    = 3'd0;
   localparam logic [2:0] ST_REPLACED = 3'd1;
   localparam logic [2:0] ST_FOUND    = 3'd2;
   localparam logic [2:0] ST_MISSING  = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;
   localparam logic [2:0] ST_BADKEY   = 3'd5;

   typedef struct packed {
      logic load;
      logic hash_step;
      logic hash_part;
      logic probe_start;
      logic probe_read;
      logic probe_next;
      logic write_new;
      logic write_value;
      logic set_result;
      logic [2:0] result_status;
      logic result_slot;
      logic result_value;
   } cmd_type;

   typedef struct packed {
      logic bad_key;
      logic over_load;
      logic is_add;
      logic hash_done;
      logic slot_empty;
      logic slot_match;
      logic pass_done;
   } sts_type;

endpackage

@@ design/linear_probe_hash_table_top.sv @@
// ----------------------------------------------------------------------------
// Linear probe hash table
// Open addressing table with FNV-1a hashing and linear probing.
// ----------------------------------------------------------------------------
//  channel  handshake        word
//  req_     valid / stall    action, key bytes, key length, store value
//  rsp_     valid / stall    status, found value, slot index
//  csr_     valid / ready    load limit
//
// A request is accepted in an idle cycle, then passes through the checks, a
// MULA/MULB state pair per key byte in the hash multiplier, the probe start,
// a READ/TEST pair per probed slot and the result state; a refused key or
// load goes from the checks straight to the result, and a full pass from READ.
// Slot occupancy bits are cleared at once by the synchronous reset.
// One request is in flight at a time; a stalled word holds its result.
module linear_probe_hash_table_top #(
   parameter int TABLE_SLOTS   = 256,
   parameter int VALUE_BITS    = 32,
   parameter int MAX_KEY_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [63:0] req_key_bytes,
   input  logic [3:0]  req_key_length,
   input  logic [31:0] req_store_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_found_value,
   output logic [7:0]  rsp_slot_index,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_load_limit
);

   lpht_pkg::cmd_type cmd;
   lpht_pkg::sts_type sts;
   logic              busy;
   logic [7:0]        limit_ff;

   assign csr_ready = !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= lpht_pkg::LOAD_RESET;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_load_limit;
      end
   end

   lpht_control u_control (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .busy, .cmd, .sts
   );

   lpht_datapath #(
      .TABLE_SLOTS(TABLE_SLOTS), .VALUE_BITS(VALUE_BITS),
      .MAX_KEY_BYTES(MAX_KEY_BYTES)
   ) u_datapath (
      .clock, .reset, .cmd, .sts, .load_limit(limit_ff),
      .req_action, .req_key_bytes, .req_key_length, .req_store_value,
      .rsp_status, .rsp_found_value, .rsp_slot_index
   );

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request accepted while result pending");
   a_found_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != lpht_pkg::ST_FOUND) |-> (rsp_found_value == 32'd0))
      else $error("value on non-found result");
   a_rsp_next: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !rsp_valid) else $error("result too early");

endmodule

@@ design/lpht_datapath.sv @@
// ----------------------------------------------------------------------------
// Linear probe hash table datapath
// Request registers, serial FNV-1a unit, slot memories and probe counter.
// ----------------------------------------------------------------------------
module lpht_datapath #(
   parameter int TABLE_SLOTS   = 256,
   parameter int VALUE_BITS    = 32,
   parameter int MAX_KEY_BYTES = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lpht_pkg::cmd_type    cmd,
   output lpht_pkg::sts_type    sts,
   input  logic [7:0]           load_limit,
   input  logic                 req_action,
   input  logic [63:0]          req_key_bytes,
   input  logic [3:0]           req_key_length,
   input  logic [31:0]          req_store_value,
   output logic [2:0]           rsp_status,
   output logic [31:0]          rsp_found_value,
   output logic [7:0]           rsp_slot_index
);

   localparam int AW = $clog2(TABLE_SLOTS);
   localparam int CW = AW + 1;
   localparam int LW = lpht_pkg::LOAD_SHIFT;
   localparam int VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;

   logic            add_ff;
   logic [63:0]     key_ff;
   logic [3:0]      len_ff, left_ff;
   logic [VALUE_BITS-1:0] val_ff;
   logic [63:0]     hash_ff, xored_ff;
   logic [40:0]     lo_prod_ff;
   logic [31:0]     hi_prod_ff;
   logic [AW-1:0]   idx_ff;
   logic [CW-1:0]   probes_ff, count_ff;
   logic [2:0]      status_ff;
   logic [31:0]     found_ff;
   logic [7:0]      slot_ff;

   logic [TABLE_SLOTS-1:0] used_ff;
   logic [3:0]            mem_len  [TABLE_SLOTS];
   logic [63:0]           mem_key  [TABLE_SLOTS];
   logic [63:0]           mem_hash [TABLE_SLOTS];
   logic [VALUE_BITS-1:0] mem_val  [TABLE_SLOTS];
   logic [3:0]            rd_len_ff;
   logic [63:0]           rd_key_ff, rd_hash_ff;
   logic [VALUE_BITS-1:0] rd_val_ff;
   logic                  rd_used_ff;

   logic [63:0]      key_mask;
   logic [7:0]       cur_byte;
   logic [CW+LW-1:0] load_scaled;

   always_comb begin
      key_mask = (req_key_length >= 4'd8) ? '1 :
                 ((64'd1 << {req_key_length[2:0], 3'b000}) - 64'd1);
      cur_byte = key_ff[{len_ff[2:0] - left_ff[2:0], 3'b000} +: 8];
      load_scaled = {count_ff, {LW{1'b0}}} >> AW;
   end

   assign sts.bad_key    = (len_ff == 4'd0) || (len_ff > 4'(MAX_KEY_BYTES));
   assign sts.over_load  = load_scaled > (CW+LW)'(load_limit);
   assign sts.is_add     = add_ff;
   assign sts.hash_done  = (left_ff == 4'd0);
   assign sts.slot_empty = !rd_used_ff;
   assign sts.slot_match = rd_used_ff && (rd_hash_ff == hash_ff) &&
                           (rd_len_ff == len_ff) && (rd_key_ff == key_ff);
   assign sts.pass_done  = (probes_ff == CW'(TABLE_SLOTS));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         add_ff  <= req_action;
         key_ff  <= req_key_bytes & key_mask;
         len_ff  <= req_key_length;
         left_ff <= req_key_length;
         val_ff  <= VALUE_BITS'(req_store_value);
         hash_ff <= lpht_pkg::FNV_BASIS;
      end else if (cmd.hash_part) begin
         // First half of a byte step: partial products of the multiply.
         xored_ff   <= hash_ff ^ {56'd0, cur_byte};
         lo_prod_ff <= 41'(hash_ff[31:0] ^ {24'd0, cur_byte}) * 41'h1b3;
         hi_prod_ff <= hash_ff[63:32] * 32'h1b3;
      end else if (cmd.hash_step) begin
         // Product of the xored hash and the prime: 0x100000001b3 = 2^40 + 0x1b3.
         hash_ff <= {xored_ff[23:0], 40'd0} + {hi_prod_ff, 32'd0} + {23'd0, lo_prod_ff};
         left_ff <= left_ff - 4'd1;
      end
      if (cmd.probe_start) begin
         idx_ff    <= hash_ff[AW-1:0];
         probes_ff <= '0;
      end else if (cmd.probe_next) begin
         idx_ff    <= idx_ff + AW'(1);
         probes_ff <= probes_ff + CW'(1);
      end
      if (cmd.probe_read) begin
         rd_used_ff <= used_ff[idx_ff];
         rd_len_ff  <= mem_len[idx_ff];
         rd_key_ff  <= mem_key[idx_ff];
         rd_hash_ff <= mem_hash[idx_ff];
         rd_val_ff  <= mem_val[idx_ff];
      end
      if (cmd.write_new) begin
         mem_len[idx_ff]  <= len_ff;
         mem_key[idx_ff]  <= key_ff;
         mem_hash[idx_ff] <= hash_ff;
      end
      if (cmd.write_new || cmd.write_value) begin
         mem_val[idx_ff] <= val_ff;
      end
      if (cmd.set_result) begin
         status_ff <= cmd.result_status;
         found_ff  <= cmd.result_value ? 32'(rd_val_ff[VW-1:0]) : 32'd0;
         slot_ff   <= cmd.result_slot ? 8'(idx_ff) : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (cmd.write_new) begin
            used_ff[idx_ff] <= 1'b1;
            count_ff        <= count_ff + CW'(1);
         end
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_found_value = found_ff;
   assign rsp_slot_index  = slot_ff;

endmodule

@@ design/lpht_control.sv @@
// ----------------------------------------------------------------------------
// Linear probe hash table controller
// Sequences key and load checks, hashing, probing, update and result.
// ----------------------------------------------------------------------------
module lpht_control (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               busy,
   output lpht_pkg::cmd_type  cmd,
   input  lpht_pkg::sts_type  sts
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_MULA  = 3'd2;
   localparam logic [2:0] S_MULB  = 3'd3;
   localparam logic [2:0] S_READ  = 3'd4;
   localparam logic [2:0] S_TEST  = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   logic [2:0] state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign busy      = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.bad_key) begin
               cmd.set_result    = 1'b1;
               cmd.result_status = lpht_pkg::ST_BADKEY;
               state_in          = S_OUT;
            end else if (sts.is_add && sts.over_load) begin
               cmd.set_result    = 1'b1;
               cmd.result_status = lpht_pkg::ST_FULL;
               state_in          = S_OUT;
            end else begin
               state_in = S_MULA;
            end
         end
         S_MULA: begin
            if (sts.hash_done) begin
               cmd.probe_start = 1'b1;
               state_in        = S_READ;
            end else begin
               cmd.hash_part = 1'b1;
               state_in      = S_MULB;
            end
         end
         S_MULB: begin
            cmd.hash_step = 1'b1;
            state_in      = S_MULA;
         end
         S_READ: begin
            if (sts.pass_done) begin
               cmd.set_result    = 1'b1;
               cmd.result_status = sts.is_add ? lpht_pkg::ST_FULL : lpht_pkg::ST_MISSING;
               state_in          = S_OUT;
            end else begin
               cmd.probe_read = 1'b1;
               state_in       = S_TEST;
            end
         end
         S_TEST: begin
            if (sts.slot_empty) begin
               cmd.set_result = 1'b1;
               if (sts.is_add) begin
                  cmd.write_new     = 1'b1;
                  cmd.result_status = lpht_pkg::ST_ADDED;
                  cmd.result_slot   = 1'b1;
               end else begin
                  cmd.result_status = lpht_pkg::ST_MISSING;
               end
               state_in = S_OUT;
            end else if (sts.slot_match) begin
               cmd.set_result  = 1'b1;
               cmd.result_slot = 1'b1;
               if (sts.is_add) begin
                  cmd.write_value   = 1'b1;
                  cmd.result_status = lpht_pkg::ST_REPLACED;
               end else begin
                  cmd.result_value  = 1'b1;
                  cmd.result_status = lpht_pkg::ST_FOUND;
               end
               state_in = S_OUT;
            end else begin
               cmd.probe_next = 1'b1;
               state_in       = S_READ;
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
